// ===== sv/lis_pkg.sv =====
`timescale 1ns / 1ps

package lis_pkg;

  localparam int unsigned MaxItems = 256;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned LenW     = IdxW + 1;
  localparam int unsigned DataW    = 32;

  typedef struct packed {
    logic                    we;
    logic [IdxW-1:0]         waddr;
    logic signed [DataW-1:0] wdata;
    logic                    re;
    logic [IdxW-1:0]         raddr;
  } lis_mem_req_t;

  typedef struct packed {
    logic [LenW-1:0] lis_length;
    logic [IdxW-1:0] slot_written;
    logic            dropped;
  } lis_res_t;

endpackage

// ===== sv/lis_in_if.sv =====
`timescale 1ns / 1ps

interface lis_in_if;
  import lis_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    start_req;

  modport source (output valid, output value, output start_req, input ready);
  modport sink (input valid, input value, input start_req, output ready);
endinterface

// ===== sv/lis_out_if.sv =====
`timescale 1ns / 1ps

interface lis_out_if;
  import lis_pkg::*;

  logic            valid;
  logic            ready;
  logic [LenW-1:0] lis_length;
  logic [IdxW-1:0] slot_written;
  logic            dropped;

  modport source (output valid, output lis_length, output slot_written, output dropped,
                  input ready);
  modport sink (input valid, input lis_length, input slot_written, input dropped,
                output ready);
endinterface

// ===== sv/lis_tails_ram.sv =====
`timescale 1ns / 1ps

module lis_tails_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/lis_search.sv =====
`timescale 1ns / 1ps

module lis_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  lis_in_if.sink            in_i,
  output logic              res_valid_o,
  output lis_pkg::lis_res_t res_o,
  input  logic              res_ready_i
);
  import lis_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic signed [DataW-1:0] first_q, first_d;
  logic signed [DataW-1:0] last_q, last_d;
  logic [LenW-1:0]         len_q, len_d;
  logic [IdxW-1:0]         lo_q, lo_d;
  logic [IdxW-1:0]         hi_q, hi_d;
  logic [IdxW-1:0]         mid_q, mid_d;
  lis_res_t                res_q, res_d;

  lis_mem_req_t            mem_req;
  logic [DataW-1:0]        rd_data;
  logic [LenW-1:0]         len_m1;
  logic [IdxW-1:0]         last_idx;
  logic                    fin;
  logic [IdxW-1:0]         fin_slot;
  logic                    ge;
  logic [IdxW-1:0]         nlo;
  logic [IdxW-1:0]         nhi;

  function automatic logic [IdxW-1:0] mid_of(logic [IdxW-1:0] l, logic [IdxW-1:0] h);
    logic [IdxW:0] sum;
    sum = {1'b0, l} + {1'b0, h} - {{IdxW{1'b0}}, 1'b1};
    return sum[IdxW:1];
  endfunction

  lis_tails_ram #(
    .Depth(MaxItems),
    .Width(DataW)
  ) u_tails (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .rdata_o(rd_data)
  );

  assign len_m1      = len_q - LenW'(1);
  assign last_idx    = len_m1[IdxW-1:0];
  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  assign ge  = ($signed(rd_data) >= key_q);
  assign nlo = ge ? lo_q : mid_q + IdxW'(1);
  assign nhi = ge ? mid_q : hi_q;

  always_comb begin
    state_d  = state_q;
    key_d    = key_q;
    first_d  = first_q;
    last_d   = last_q;
    len_d    = len_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    res_d    = res_q;
    mem_req  = '0;
    fin      = 1'b0;
    fin_slot = hi_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          key_d = in_i.value;
          if (in_i.start_req || (len_q == '0)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_i.value;
            first_d       = in_i.value;
            last_d        = in_i.value;
            len_d         = LenW'(1);
            res_d         = '{lis_length: LenW'(1), slot_written: '0, dropped: 1'b0};
            state_d       = S_DONE;
          end else if (in_i.value < first_q) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = in_i.value;
            first_d       = in_i.value;
            if (len_q == LenW'(1)) begin
              last_d = in_i.value;
            end
            res_d   = '{lis_length: len_q, slot_written: '0, dropped: 1'b0};
            state_d = S_DONE;
          end else if (in_i.value > last_q) begin
            if (len_q < LenW'(MaxItems)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = len_q[IdxW-1:0];
              mem_req.wdata = in_i.value;
              last_d        = in_i.value;
              len_d         = len_q + LenW'(1);
              res_d         = '{lis_length: len_q + LenW'(1),
                                slot_written: len_q[IdxW-1:0], dropped: 1'b0};
            end else begin
              res_d = '{lis_length: len_q, slot_written: '0, dropped: 1'b1};
            end
            state_d = S_DONE;
          end else begin
            lo_d    = '0;
            hi_d    = last_idx;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (lo_q == hi_q) begin
          fin      = 1'b1;
          fin_slot = hi_q;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = mid_of(lo_q, hi_q);
          mid_d         = mid_of(lo_q, hi_q);
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        lo_d = nlo;
        hi_d = nhi;
        if (nlo == nhi) begin
          fin      = 1'b1;
          fin_slot = nhi;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = mid_of(nlo, nhi);
          mid_d         = mid_of(nlo, nhi);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = fin_slot;
      mem_req.wdata = key_q;
      if (fin_slot == '0) begin
        first_d = key_q;
      end
      if (fin_slot == last_idx) begin
        last_d = key_q;
      end
      res_d   = '{lis_length: len_q, slot_written: fin_slot, dropped: 1'b0};
      state_d = S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    first_q <= first_d;
    last_q  <= last_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    res_q   <= res_d;
  end

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxItems))
    else $error("tails length beyond capacity");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH || state_q == S_CHECK) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> ({1'b0, mem_req.raddr} < len_q))
    else $error("tails read beyond length");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.dropped) |-> (len_q == LenW'(MaxItems)))
    else $error("drop without full table");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE && $stable(res_q)))
    else $error("result lost while stalled");

endmodule

// ===== sv/longest_increasing_subsequence_core.sv =====
`timescale 1ns / 1ps

// Streams signed 32-bit values and reports, per transaction, the length of the longest
// strictly increasing subsequence since the last start, the tails slot written and a drop
// flag for an append at full capacity (256 tails). An item that starts a sequence, lands
// below tail 0 or above the last tail goes straight from accept to the result state,
// using cached copies of the first and last tails; any other item runs a binary search
// over the tails memory, one registered read per step, and then writes the key into the
// slot it found. The next input transaction is taken as soon as the result moves to the
// output register, even while that register still waits for the sink.
module longest_increasing_subsequence_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lis_in_if.sink      in_i,
  lis_out_if.source   out_o
);
  import lis_pkg::*;

  logic     res_valid;
  logic     res_ready;
  lis_res_t res;
  logic     out_valid_q;
  lis_res_t out_q;

  lis_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lis_length   = out_q.lis_length;
  assign out_o.slot_written = out_q.slot_written;
  assign out_o.dropped      = out_q.dropped;

endmodule
